FILE: design/fut_pkg.sv
// ----------------------------------------------------------------------------
// fut_pkg - shared types and constants for the form-urlencoded tokenizer
// Result and bundle layouts, delimiter codes, escape phase codes.
// ----------------------------------------------------------------------------
package fut_pkg;

   // special characters of a form body
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // most result words one input byte can cause
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);
   localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);

   // default depth of the front-to-back queue, in bundles
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,   // no escape pending
      PH_PCT   = 2'd1,   // '%' seen
      PH_DIGIT = 2'd2    // '%' and one hex digit seen
   } esc_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       in_value;
      logic       pair_end;
      logic       pair_kept;
      logic       run_last;
   } result_type;

   // all result words caused by one input byte
   typedef struct packed {
      logic [COUNT_W-1:0]                 count;
      result_type [MAX_RESULTS-1:0]       slot;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

FILE: design/fut_ifs.sv
// ----------------------------------------------------------------------------
// fut_ifs - channel interfaces of the form-urlencoded tokenizer
// Valid/ready request channel (raw bytes) and response channel (tokens).
// ----------------------------------------------------------------------------
interface fut_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       body_end;

   modport source (output valid, output in_byte, output body_end, input ready);
   modport sink   (input valid, input in_byte, input body_end, output ready);
endinterface

interface fut_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       in_value;
   logic       pair_end;
   logic       pair_kept;
   logic       run_last;

   modport source (output valid, output out_byte, output has_byte, output in_value,
                   output pair_end, output pair_kept, output run_last, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input in_value,
                   input pair_end, input pair_kept, input run_last, output ready);
endinterface

FILE: design/fut_front.sv
// ----------------------------------------------------------------------------
// fut_front - byte classifier and escape tracker
// Takes one raw byte per cycle while accept is high; builds its result bundle.
// ----------------------------------------------------------------------------
module fut_front
   import fut_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       body_end,
   output logic       push,
   output bundle_type bundle
);

   esc_phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   logic          side_ff, side_in;

   // {valid, value} of a hex digit, either case
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   function automatic result_type data_word(input logic [7:0] b, input logic side);
      result_type r;
      r = '0;
      r.out_byte = b;
      r.has_byte = 1'b1;
      r.in_value = side;
      return r;
   endfunction

   function automatic result_type marker_word(input logic kept);
      result_type r;
      r = '0;
      r.pair_end  = 1'b1;
      r.pair_kept = kept;
      return r;
   endfunction

   function automatic bundle_type append(input bundle_type b, input result_type r);
      bundle_type o;
      o = b;
      o.slot[o.count[SLOT_W-1:0]] = r;
      o.count = o.count + 1'b1;
      return o;
   endfunction

   // emit a pending escape raw: '%' then the held digit
   function automatic bundle_type flush(input bundle_type b, input esc_phase_type ph,
                                        input logic [7:0] held, input logic side);
      bundle_type o;
      o = b;
      if (ph == PH_PCT || ph == PH_DIGIT) o = append(o, data_word(CH_PCT, side));
      if (ph == PH_DIGIT)                 o = append(o, data_word(held, side));
      return o;
   endfunction

   always_comb begin
      bundle_type           b;
      esc_phase_type        ph;
      logic [7:0]           held;
      logic                 side;
      logic                 was_amp;
      logic                 plain;
      logic [4:0]           hc;
      logic [4:0]           hh;
      logic [SLOT_W-1:0]    last_idx;

      b       = '0;
      ph      = phase_ff;
      held    = held_ff;
      side    = side_ff;
      was_amp = 1'b0;
      plain   = 1'b0;
      hc      = hex_decode(in_byte);
      hh      = hex_decode(held_ff);

      if (in_byte == CH_AMP) begin
         b       = flush(b, ph, held, side);
         ph      = PH_IDLE;
         b       = append(b, marker_word(side));
         side    = 1'b0;
         was_amp = 1'b1;
      end else if (in_byte == CH_EQ && !side) begin
         b    = flush(b, ph, held, side);
         ph   = PH_IDLE;
         side = 1'b1;
      end else begin
         case (phase_ff)
            PH_PCT: begin
               if (hc[4]) begin
                  held = in_byte;
                  ph   = PH_DIGIT;
               end else begin
                  b     = flush(b, ph, held, side);
                  ph    = PH_IDLE;
                  plain = 1'b1;
               end
            end
            PH_DIGIT: begin
               if (hc[4]) begin
                  b  = append(b, data_word({hh[4] ? hh[3:0] : 4'd0, hc[3:0]}, side));
                  ph = PH_IDLE;
               end else begin
                  b     = flush(b, ph, held, side);
                  ph    = PH_IDLE;
                  plain = 1'b1;
               end
            end
            default: begin
               ph    = PH_IDLE;
               plain = 1'b1;
            end
         endcase
      end

      // non-delimiter byte with no escape pending
      if (plain) begin
         if (in_byte == CH_PLUS)     b  = append(b, data_word(CH_SPACE, side));
         else if (in_byte == CH_PCT) ph = PH_PCT;
         else                        b  = append(b, data_word(in_byte, side));
      end

      if (body_end) begin
         b = flush(b, ph, held, side);
         if (!was_amp) b = append(b, marker_word(side));
         ph   = PH_IDLE;
         held = 8'd0;
         side = 1'b0;
      end

      last_idx = SLOT_W'(b.count - 1'b1);
      if (b.count != '0) b.slot[last_idx].run_last = 1'b1;

      bundle   = b;
      phase_in = ph;
      held_in  = held;
      side_in  = side;
   end

   assign push = accept && (bundle.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'd0;
         side_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         side_ff  <= side_in;
      end
   end

endmodule

FILE: design/fut_queue.sv
// ----------------------------------------------------------------------------
// fut_queue - bundle queue between front and back
// Small circular buffer; decouples byte intake from result delivery.
// ----------------------------------------------------------------------------
module fut_queue
   import fut_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type wr_data,
   input  logic       pop,
   output bundle_type rd_data,
   output q_stat_type stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   bundle_type        mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rd_data    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/fut_back.sv
// ----------------------------------------------------------------------------
// fut_back - result serializer
// Walks each bundle one word per cycle into the response register while ready.
// ----------------------------------------------------------------------------
module fut_back
   import fut_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type head,
   input  q_stat_type q_stat,
   output logic       pop,
   fut_rsp_if.source  rsp_ch
);

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   result_type        data_ff;
   logic              load;
   logic              last_slot;

   assign load      = !q_stat.empty && (!valid_ff || rsp_ch.ready);
   assign last_slot = (idx_ff == SLOT_W'(head.count - 1'b1));
   assign pop       = load && last_slot;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = last_slot ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= head.slot[idx_ff];
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_byte  = data_ff.out_byte;
   assign rsp_ch.has_byte  = data_ff.has_byte;
   assign rsp_ch.in_value  = data_ff.in_value;
   assign rsp_ch.pair_end  = data_ff.pair_end;
   assign rsp_ch.pair_kept = data_ff.pair_kept;
   assign rsp_ch.run_last  = data_ff.run_last;

endmodule

FILE: design/form_urlencoded_tokenizer.sv
// ----------------------------------------------------------------------------
// form_urlencoded_tokenizer - streaming form-urlencoded body decoder
// Splits pairs and key/value, decodes '+' and percent escapes, marks pair ends.
// ----------------------------------------------------------------------------
// The block takes one raw body byte per cycle on req_ch, while its queue has
// room, and returns decoded words on rsp_ch: data words tagged key or value,
// and a marker word at the end of every pair (pair_kept low means the pair
// had no '=' and should be dropped); run_last flags the final word caused by
// each input byte. A byte yields zero to four words, so the sustained rate is
// one byte per cycle or one word per cycle, whichever is slower: the back end
// emits one word per cycle while rsp_ch is ready. A byte with no words ('%',
// a first hex digit, the split '=') is taken but pushes nothing downstream.
// The front end builds a byte's whole bundle of words in the cycle it is
// taken; a queue of QUEUE_DEPTH bundles lets it run ahead while the response
// side stalls. req_ch.ready drops only when that queue is full. A byte's
// first word goes through the queue write, then the response register load.
// ----------------------------------------------------------------------------
module form_urlencoded_tokenizer
   import fut_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   fut_req_if.sink   req_ch,
   fut_rsp_if.source rsp_ch
);

   logic       accept;
   logic       push;
   logic       pop;
   bundle_type wr_bundle;
   bundle_type head;
   q_stat_type q_stat;

   // intake stalls only on a full queue
   assign req_ch.ready = !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;

   // front: classify byte, track escape and key/value side
   fut_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_ch.in_byte),
      .body_end (req_ch.body_end),
      .push     (push),
      .bundle   (wr_bundle)
   );

   // bundles of words waiting for delivery
   fut_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_bundle),
      .pop     (pop),
      .rd_data (head),
      .stat    (q_stat)
   );

   // back: one word per cycle into the response register while rsp_ch is ready
   fut_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTH
   // never take a byte while the queue has no room
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !accept)
      else $error("byte accepted with full queue");

   // a bundle pushed into an empty queue with a free output: queue write,
   // then response load, after which valid is up
   a_push_reaches_output: assert property (@(posedge clock) disable iff (reset)
      push && q_stat.empty && !rsp_ch.valid |-> ##2 rsp_ch.valid)
      else $error("pushed bundle did not reach response");

   // no word appears from nothing
   a_no_phantom_word: assert property (@(posedge clock) disable iff (reset)
      !push && q_stat.empty && (!rsp_ch.valid || rsp_ch.ready) |=> !rsp_ch.valid)
      else $error("response valid without queued word");
`endif

endmodule

FILE: tb/tb_form_urlencoded_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_form_urlencoded_tokenizer - self-checking bench for the body tokenizer
// Drives raw form bodies over the request channel and checks every response
// word against an in-bench decoder. Starts with a directed set of escapes and
// delimiters, then random bodies. Both sides stall at random, and the run
// includes one long response hold-off and at least one full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_form_urlencoded_tokenizer;
   import fut_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 380;
   localparam int unsigned IDLE_PCT     = 25;
   localparam int unsigned HOLDOFF_LEN  = 80;
   localparam int unsigned HOLDOFF_AT   = 200;  // bytes accepted before the hold-off
   localparam int unsigned DRAIN_AT     = 300;  // queued bytes before the drain pause
   localparam int unsigned TAIL_CYCLES  = 20;

   // one raw byte of a body, as queued for the driver
   typedef struct packed {
      logic [7:0] b;
      logic       last;    // body_end
      logic       drain;   // wait for all words before offering this byte
   } body_byte_type;

   logic clock;
   logic reset = 1'b1;

   // bench-side drive registers; the interfaces see them through assigns
   logic       drv_valid  = 1'b0;
   logic [7:0] drv_byte   = 8'h00;
   logic       drv_end    = 1'b0;
   logic       sink_ready = 1'b0;

   fut_req_if req_ch ();
   fut_rsp_if rsp_ch ();

   assign req_ch.valid    = drv_valid;
   assign req_ch.in_byte  = drv_byte;
   assign req_ch.body_end = drv_end;
   assign rsp_ch.ready    = sink_ready;

   form_urlencoded_tokenizer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   body_byte_type pending[$];      // bytes still to be offered
   logic [7:0] body_buf[$];        // body under construction
   result_type step_words[$];      // words caused by the byte being decoded
   result_type expected_words[$];  // decoded words not yet seen on rsp_ch

   // decoder state, mirrors the block's
   esc_phase_type esc_state  = PH_IDLE;
   logic [7:0]    held_digit = 8'h00;
   logic          on_value   = 1'b0;

   int unsigned items_queued   = 0;
   int unsigned items_accepted = 0;
   int unsigned words_seen     = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned stall_left     = 0;
   logic        stall_done     = 1'b0;
   logic        req_taken      = 1'b0;
   result_type  want_word;

   // a stretch of the run with no idling on either side
   wire quiet = (items_accepted >= 100) && (items_accepted < 180);

   // -------------------------------------------------------------------------
   // decoder
   // -------------------------------------------------------------------------
   function automatic int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // markers carry no byte and no side tag
   task automatic emit_word(logic [7:0] b, logic is_data, logic is_end, logic kept);
      result_type w;
      w.out_byte  = is_data ? b : 8'h00;
      w.has_byte  = is_data;
      w.in_value  = is_data & on_value;
      w.pair_end  = is_end;
      w.pair_kept = is_end & kept;
      w.run_last  = 1'b0;
      step_words.push_back(w);
   endtask

   // a pending escape that will not complete goes out raw
   task automatic flush_escape();
      if (esc_state == PH_PCT) begin
         emit_word(CH_PCT, 1'b1, 1'b0, 1'b0);
      end else if (esc_state == PH_DIGIT) begin
         emit_word(CH_PCT, 1'b1, 1'b0, 1'b0);
         emit_word(held_digit, 1'b1, 1'b0, 1'b0);
      end
      esc_state = PH_IDLE;
   endtask

   task automatic plain_char(logic [7:0] c);
      if (c == CH_PLUS) begin
         emit_word(CH_SPACE, 1'b1, 1'b0, 1'b0);
      end else if (c == CH_PCT) begin
         esc_state = PH_PCT;
      end else begin
         emit_word(c, 1'b1, 1'b0, 1'b0);
      end
   endtask

   task automatic decode_byte(logic [7:0] c, logic last);
      int         hi;
      int         lo;
      logic       was_amp;
      result_type w;
      step_words.delete();
      was_amp = 1'b0;
      if (c == CH_AMP) begin
         flush_escape();
         emit_word(8'h00, 1'b0, 1'b1, on_value);
         on_value = 1'b0;
         was_amp  = 1'b1;
      end else if (c == CH_EQ && !on_value) begin
         // flushed chars still belong to the key
         flush_escape();
         on_value = 1'b1;
      end else if (esc_state == PH_PCT) begin
         if (hex_value(c) >= 0) begin
            held_digit = c;
            esc_state  = PH_DIGIT;
         end else begin
            flush_escape();
            plain_char(c);
         end
      end else if (esc_state == PH_DIGIT) begin
         lo = hex_value(c);
         if (lo >= 0) begin
            hi = hex_value(held_digit);
            if (hi < 0) hi = 0;
            emit_word(8'((hi << 4) | lo), 1'b1, 1'b0, 1'b0);
            esc_state = PH_IDLE;
         end else begin
            flush_escape();
            plain_char(c);
         end
      end else begin
         esc_state = PH_IDLE;
         plain_char(c);
      end
      // end of body: flush, close the pair unless '&' already did, clear state
      if (last) begin
         flush_escape();
         if (!was_amp) emit_word(8'h00, 1'b0, 1'b1, on_value);
         esc_state  = PH_IDLE;
         held_digit = 8'h00;
         on_value   = 1'b0;
      end
      foreach (step_words[i]) begin
         w          = step_words[i];
         w.run_last = (i == step_words.size() - 1);
         expected_words.push_back(w);
      end
   endtask

   // -------------------------------------------------------------------------
   // stimulus builders
   // -------------------------------------------------------------------------
   task automatic queue_byte(logic [7:0] b, logic last, logic drain);
      body_byte_type item;
      item.b     = b;
      item.last  = last;
      item.drain = drain;
      pending.push_back(item);
      items_queued++;
   endtask

   // body_end goes on the final char only when close is set
   task automatic queue_text(string s, logic close);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i], close && (i == s.len() - 1), 1'b0);
   endtask

   function automatic logic [7:0] hex_char(int v);
      if (v < 10) return 8'("0" + v);
      return ($urandom_range(1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   task automatic add_token();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         body_buf.push_back(($urandom_range(3) == 0) ? 8'("0" + $urandom_range(9))
                                                      : 8'("a" + $urandom_range(25)));
      end else if (pick < 50) begin
         body_buf.push_back(CH_PLUS);
      end else if (pick < 70) begin
         body_buf.push_back(CH_PCT);
         body_buf.push_back(hex_char($urandom_range(15)));
         body_buf.push_back(hex_char($urandom_range(15)));
      end else if (pick < 78) begin
         // broken escape: maybe one digit, then a non-hex char
         body_buf.push_back(CH_PCT);
         if ($urandom_range(1) != 0) body_buf.push_back(hex_char($urandom_range(15)));
         case ($urandom_range(2))
            0: body_buf.push_back(CH_PLUS);
            1: body_buf.push_back(CH_PCT);
            default: body_buf.push_back(8'("g" + $urandom_range(19)));
         endcase
      end else if (pick < 92) begin
         body_buf.push_back(8'($urandom_range(255)));
      end else begin
         body_buf.push_back(CH_EQ);
      end
   endtask

   task automatic add_random_body(logic drain);
      int pairs;
      int ntok;
      body_buf.delete();
      pairs = $urandom_range(1, 4);
      for (int p = 0; p < pairs; p++) begin
         if (p > 0) body_buf.push_back(CH_AMP);
         ntok = $urandom_range(0, 4);
         repeat (ntok) add_token();
         if ($urandom_range(99) < 85) begin
            body_buf.push_back(CH_EQ);
            ntok = $urandom_range(0, 5);
            repeat (ntok) add_token();
         end
      end
      case ($urandom_range(9))
         0, 1: body_buf.push_back(CH_AMP);   // empty trailing pair
         2: begin                            // escape cut by end of body
            body_buf.push_back(CH_PCT);
            if ($urandom_range(1) != 0) body_buf.push_back(hex_char($urandom_range(15)));
         end
         default: ;
      endcase
      if (body_buf.size() == 0) body_buf.push_back("z");
      foreach (body_buf[i])
         queue_byte(body_buf[i], i == body_buf.size() - 1, drain && (i == 0));
   endtask

   // -------------------------------------------------------------------------
   // request driver: holds a byte until taken, idles at random
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            decode_byte(pending[0].b, pending[0].last);
            pending.delete(0);
            items_accepted <= items_accepted + 1;
         end
         if (!drv_valid || req_taken) begin
            if (pending.size() != 0 && !(pending[0].drain && expected_words.size() != 0)
                && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               drv_valid <= 1'b1;
               drv_byte  <= pending[0].b;
               drv_end   <= pending[0].last;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // response ready: random stalls plus one long hold-off while bytes keep
   // coming, so the block's queue fills and req ready drops
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
      end else if (stall_left != 0) begin
         sink_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_done && items_accepted >= HOLDOFF_AT) begin
         sink_ready <= 1'b0;
         stall_left <= HOLDOFF_LEN;
         stall_done <= 1'b1;
      end else begin
         sink_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // -------------------------------------------------------------------------
   // response monitor
   // -------------------------------------------------------------------------
   task automatic report_mismatch(string field, int got, int want);
      $display("ERROR word %0d at %0t: %s got 0x%0h want 0x%0h",
               words_seen, $time, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, out_byte", int'(rsp_ch.out_byte), 0);
         end else begin
            want_word = expected_words.pop_front();
            if (rsp_ch.out_byte !== want_word.out_byte)
               report_mismatch("out_byte", int'(rsp_ch.out_byte),
                               int'(want_word.out_byte));
            if (rsp_ch.has_byte !== want_word.has_byte)
               report_mismatch("has_byte", int'(rsp_ch.has_byte),
                               int'(want_word.has_byte));
            if (rsp_ch.in_value !== want_word.in_value)
               report_mismatch("in_value", int'(rsp_ch.in_value),
                               int'(want_word.in_value));
            if (rsp_ch.pair_end !== want_word.pair_end)
               report_mismatch("pair_end", int'(rsp_ch.pair_end),
                               int'(want_word.pair_end));
            if (rsp_ch.pair_kept !== want_word.pair_kept)
               report_mismatch("pair_kept", int'(rsp_ch.pair_kept),
                               int'(want_word.pair_kept));
            if (rsp_ch.run_last !== want_word.run_last)
               report_mismatch("run_last", int'(rsp_ch.run_last),
                               int'(want_word.run_last));
         end
         words_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout: %0d words still expected", expected_words.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      // directed: escape cut by end of body
      queue_text("k%4", 1'b1);
      // bad escape with held digit, '+', '%%' restart, escape cut by '=',
      // lowercase escape, repeated '=' as data, byte extremes,
      // escape cut by '&', pair with no '=' closed by '&' at end of body
      queue_text("%4g+%%=%e9==", 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_text("%A&x&", 1'b1);
      // four words from one byte: flush of '%4', space, closing marker
      queue_text("%4+", 1'b1);

      // random bodies; the last, and some begun near DRAIN_AT, wait for a full drain
      while (items_queued < RANDOM_ITEMS)
         add_random_body(items_queued >= DRAIN_AT && items_queued < DRAIN_AT + 30
                         && (items_queued % 2 == 0));
      add_random_body(1'b1);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
